// ===== rtl/lscr_pkg.sv =====
// Shared types, constants and solve microprogram for the circle radius fit.
`timescale 1ns / 1ps

package lscr_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int MIN_POINTS  = 3;
    localparam int COORD_WIDTH = 16;
    localparam int IN_W        = 16;
    localparam int CNT_W       = 9;
    localparam int W_S1        = 25;
    localparam int W_S2        = 39;
    localparam int W_SXY       = 40;
    localparam int W_S3        = 54;
    localparam int BIG_W       = 256;
    localparam int RAD_W       = 24;
    localparam int STAT_W      = 2;
    localparam int Q_W         = 50;
    localparam int DIV_SHIFT   = 50;
    localparam int SQ_W        = 52;
    localparam int SQ_ITER     = 26;
    localparam int K_W         = 6;
    localparam int RF_DEPTH    = 23;
    localparam int RF_AW       = 5;
    localparam int PC_W        = 6;

    localparam logic [RAD_W-1:0] RADIUS_MAX = '1;
    localparam logic [SQ_W-1:0]  SQ_BIT0    = SQ_W'(1) << (2 * (SQ_ITER - 1));

    typedef logic signed [BIG_W-1:0] big_t;
    typedef logic [RF_AW-1:0] rf_addr_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_DEGEN = 2'd2,
        ST_OVF   = 2'd3
    } fit_status_t;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_CHK  = 3'd4,
        OP_DIV  = 3'd5
    } uop_op_t;

    // Register file slots; the first ten are loaded from the moment sums.
    localparam rf_addr_t R_N    = 5'd0;
    localparam rf_addr_t R_SX   = 5'd1;
    localparam rf_addr_t R_SY   = 5'd2;
    localparam rf_addr_t R_SXX  = 5'd3;
    localparam rf_addr_t R_SYY  = 5'd4;
    localparam rf_addr_t R_SX3  = 5'd5;
    localparam rf_addr_t R_SY3  = 5'd6;
    localparam rf_addr_t R_SXY  = 5'd7;
    localparam rf_addr_t R_SXY2 = 5'd8;
    localparam rf_addr_t R_SX2Y = 5'd9;
    localparam rf_addr_t R_C    = 5'd10;
    localparam rf_addr_t R_D    = 5'd11;
    localparam rf_addr_t R_G    = 5'd12;
    localparam rf_addr_t R_E    = 5'd13;
    localparam rf_addr_t R_H    = 5'd14;
    localparam rf_addr_t R_S2   = 5'd15;
    localparam rf_addr_t R_DET  = 5'd16;
    localparam rf_addr_t R_PA   = 5'd17;
    localparam rf_addr_t R_PB   = 5'd18;
    localparam rf_addr_t R_NUM  = 5'd19;
    localparam rf_addr_t R_DEN  = 5'd20;
    localparam rf_addr_t R_T1   = 5'd21;
    localparam rf_addr_t R_T2   = 5'd22;

    typedef struct packed {
        uop_op_t  op;
        rf_addr_t dst;
        rf_addr_t a;
        rf_addr_t b;
    } uop_t;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic                    overflow;
        logic signed [W_S1-1:0]  sx;
        logic signed [W_S1-1:0]  sy;
        logic signed [W_S2-1:0]  sxx;
        logic signed [W_S2-1:0]  syy;
        logic signed [W_S3-1:0]  sx3;
        logic signed [W_S3-1:0]  sy3;
        logic signed [W_SXY-1:0] sxy;
        logic signed [W_S3-1:0]  sxy2;
        logic signed [W_S3-1:0]  sx2y;
    } sums_t;

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  radius;
        fit_status_t       status;
    } fit_result_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } alu_flags_t;

    function automatic uop_t mk_uop(uop_op_t op, rf_addr_t d, rf_addr_t a, rf_addr_t b);
        uop_t u;
        u.op  = op;
        u.dst = d;
        u.a   = a;
        u.b   = b;
        return u;
    endfunction

    // Solve program: normal equations, determinant check, radius numerator
    // and denominator, then the divide (root and rounding follow in hardware).
    function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = mk_uop(OP_LOAD, R_N,    R_N,    R_N);
            6'd1:  u = mk_uop(OP_LOAD, R_SX,   R_SX,   R_SX);
            6'd2:  u = mk_uop(OP_LOAD, R_SY,   R_SY,   R_SY);
            6'd3:  u = mk_uop(OP_LOAD, R_SXX,  R_SXX,  R_SXX);
            6'd4:  u = mk_uop(OP_LOAD, R_SYY,  R_SYY,  R_SYY);
            6'd5:  u = mk_uop(OP_LOAD, R_SX3,  R_SX3,  R_SX3);
            6'd6:  u = mk_uop(OP_LOAD, R_SY3,  R_SY3,  R_SY3);
            6'd7:  u = mk_uop(OP_LOAD, R_SXY,  R_SXY,  R_SXY);
            6'd8:  u = mk_uop(OP_LOAD, R_SXY2, R_SXY2, R_SXY2);
            6'd9:  u = mk_uop(OP_LOAD, R_SX2Y, R_SX2Y, R_SX2Y);
            6'd10: u = mk_uop(OP_MUL,  R_T1,   R_SXX,  R_N);
            6'd11: u = mk_uop(OP_MUL,  R_T2,   R_SX,   R_SX);
            6'd12: u = mk_uop(OP_SUB,  R_C,    R_T1,   R_T2);
            6'd13: u = mk_uop(OP_MUL,  R_T1,   R_SXY,  R_N);
            6'd14: u = mk_uop(OP_MUL,  R_T2,   R_SX,   R_SY);
            6'd15: u = mk_uop(OP_SUB,  R_D,    R_T1,   R_T2);
            6'd16: u = mk_uop(OP_MUL,  R_T1,   R_SYY,  R_N);
            6'd17: u = mk_uop(OP_MUL,  R_T2,   R_SY,   R_SY);
            6'd18: u = mk_uop(OP_SUB,  R_G,    R_T1,   R_T2);
            6'd19: u = mk_uop(OP_ADD,  R_S2,   R_SXX,  R_SYY);
            6'd20: u = mk_uop(OP_ADD,  R_T1,   R_SX3,  R_SXY2);
            6'd21: u = mk_uop(OP_MUL,  R_T1,   R_T1,   R_N);
            6'd22: u = mk_uop(OP_MUL,  R_T2,   R_S2,   R_SX);
            6'd23: u = mk_uop(OP_SUB,  R_E,    R_T1,   R_T2);
            6'd24: u = mk_uop(OP_ADD,  R_T1,   R_SX2Y, R_SY3);
            6'd25: u = mk_uop(OP_MUL,  R_T1,   R_T1,   R_N);
            6'd26: u = mk_uop(OP_MUL,  R_T2,   R_S2,   R_SY);
            6'd27: u = mk_uop(OP_SUB,  R_H,    R_T1,   R_T2);
            6'd28: u = mk_uop(OP_MUL,  R_T1,   R_C,    R_G);
            6'd29: u = mk_uop(OP_MUL,  R_T2,   R_D,    R_D);
            6'd30: u = mk_uop(OP_SUB,  R_DET,  R_T1,   R_T2);
            6'd31: u = mk_uop(OP_CHK,  R_DET,  R_DET,  R_DET);
            6'd32: u = mk_uop(OP_MUL,  R_T1,   R_H,    R_D);
            6'd33: u = mk_uop(OP_MUL,  R_T2,   R_E,    R_G);
            6'd34: u = mk_uop(OP_SUB,  R_PA,   R_T1,   R_T2);
            6'd35: u = mk_uop(OP_MUL,  R_T1,   R_E,    R_D);
            6'd36: u = mk_uop(OP_MUL,  R_T2,   R_H,    R_C);
            6'd37: u = mk_uop(OP_SUB,  R_PB,   R_T1,   R_T2);
            6'd38: u = mk_uop(OP_MUL,  R_T1,   R_PA,   R_PA);
            6'd39: u = mk_uop(OP_MUL,  R_T2,   R_PB,   R_PB);
            6'd40: u = mk_uop(OP_ADD,  R_T1,   R_T1,   R_T2);
            6'd41: u = mk_uop(OP_MUL,  R_NUM,  R_T1,   R_N);
            6'd42: u = mk_uop(OP_MUL,  R_T1,   R_PA,   R_SX);
            6'd43: u = mk_uop(OP_MUL,  R_T2,   R_PB,   R_SY);
            6'd44: u = mk_uop(OP_ADD,  R_T1,   R_T1,   R_T2);
            6'd45: u = mk_uop(OP_MUL,  R_T1,   R_T1,   R_DET);
            6'd46: u = mk_uop(OP_ADD,  R_T1,   R_T1,   R_T1);
            6'd47: u = mk_uop(OP_ADD,  R_T1,   R_T1,   R_T1);
            6'd48: u = mk_uop(OP_ADD,  R_NUM,  R_NUM,  R_T1);
            6'd49: u = mk_uop(OP_MUL,  R_T1,   R_DET,  R_DET);
            6'd50: u = mk_uop(OP_MUL,  R_T1,   R_T1,   R_S2);
            6'd51: u = mk_uop(OP_ADD,  R_T1,   R_T1,   R_T1);
            6'd52: u = mk_uop(OP_ADD,  R_T1,   R_T1,   R_T1);
            6'd53: u = mk_uop(OP_ADD,  R_NUM,  R_NUM,  R_T1);
            6'd54: u = mk_uop(OP_MUL,  R_DEN,  R_DET,  R_DET);
            6'd55: u = mk_uop(OP_MUL,  R_DEN,  R_DEN,  R_N);
            default: u = mk_uop(OP_DIV, R_NUM, R_NUM,  R_DEN);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/lscr_accum.sv =====
// Point intake: coordinate products and moment sum accumulation.
`timescale 1ns / 1ps

module lscr_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_fire,
    input  logic [lscr_pkg::IN_W-1:0]   x_in,
    input  logic [lscr_pkg::IN_W-1:0]   y_in,
    input  logic                        last_in,
    input  logic                        clr,
    output logic                        busy,
    output logic                        fit_req,
    output lscr_pkg::sums_t             sums
);
    import lscr_pkg::*;

    localparam int PAD = IN_W - COORD_WIDTH;

    typedef enum logic [1:0] {P_IDLE, P_SQ, P_CUBE, P_ADD} phase_t;

    phase_t                 phase_reg;
    logic signed [IN_W-1:0] x_reg, y_reg;
    logic                   last_reg;
    logic signed [2*IN_W-1:0] xx_reg, yy_reg, xy_reg;
    logic signed [3*IN_W-1:0] xxx_reg, yyy_reg, xyy_reg, xxy_reg;
    sums_t                  sums_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            sums_reg  <= '0;
        end
        else
        begin
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (in_fire)
                    begin
                        phase_reg <= P_SQ;
                    end
                end
                P_SQ:   phase_reg <= P_CUBE;
                P_CUBE: phase_reg <= P_ADD;
                P_ADD:
                begin
                    phase_reg <= P_IDLE;
                    if (sums_reg.count == CNT_W'(MAX_POINTS))
                    begin
                        sums_reg.overflow <= 1'b1;
                    end
                    else
                    begin
                        sums_reg.count <= sums_reg.count + CNT_W'(1);
                        sums_reg.sx    <= sums_reg.sx   + W_S1'(x_reg);
                        sums_reg.sy    <= sums_reg.sy   + W_S1'(y_reg);
                        sums_reg.sxx   <= sums_reg.sxx  + W_S2'(xx_reg);
                        sums_reg.syy   <= sums_reg.syy  + W_S2'(yy_reg);
                        sums_reg.sxy   <= sums_reg.sxy  + W_SXY'(xy_reg);
                        sums_reg.sx3   <= sums_reg.sx3  + W_S3'(xxx_reg);
                        sums_reg.sy3   <= sums_reg.sy3  + W_S3'(yyy_reg);
                        sums_reg.sxy2  <= sums_reg.sxy2 + W_S3'(xyy_reg);
                        sums_reg.sx2y  <= sums_reg.sx2y + W_S3'(xxy_reg);
                    end
                end
                default: phase_reg <= P_IDLE;
            endcase
            if (clr)
            begin
                sums_reg <= '0;
            end
        end
    end

    // Payload: coordinate capture and the two product stages.
    always_ff @(posedge clk)
    begin
        if (in_fire && phase_reg == P_IDLE)
        begin
            x_reg    <= $signed(x_in << PAD) >>> PAD;
            y_reg    <= $signed(y_in << PAD) >>> PAD;
            last_reg <= last_in;
        end
        if (phase_reg == P_SQ)
        begin
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            xy_reg <= x_reg * y_reg;
        end
        if (phase_reg == P_CUBE)
        begin
            xxx_reg <= xx_reg * x_reg;
            yyy_reg <= yy_reg * y_reg;
            xyy_reg <= yy_reg * x_reg;
            xxy_reg <= xx_reg * y_reg;
        end
    end

    assign busy    = (phase_reg != P_IDLE);
    assign fit_req = (phase_reg == P_ADD) && last_reg;
    assign sums    = sums_reg;

endmodule

// ===== rtl/lscr_alu.sv =====
// Shared wide adder/subtractor with sign and zero flags.
`timescale 1ns / 1ps

module lscr_alu (
    input  lscr_pkg::big_t       a,
    input  lscr_pkg::big_t       b,
    input  logic                 sub,
    output lscr_pkg::big_t       sum,
    output lscr_pkg::alu_flags_t flags
);
    import lscr_pkg::*;

    assign sum        = a + (sub ? ~b : b) + BIG_W'(sub);
    assign flags.neg  = sum[BIG_W-1];
    assign flags.zero = (sum == '0);

endmodule

// ===== rtl/lscr_solver.sv =====
// Microcoded fit solver: register file, shift-add multiply, divide, root.
`timescale 1ns / 1ps

module lscr_solver (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lscr_pkg::sums_t       sums,
    input  logic                  take,
    output logic                  busy,
    output lscr_pkg::fit_result_t result
);
    import lscr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_FETCH, S_EXEC, S_MUL, S_DSAT, S_DIV, S_SQRT, S_ROUND, S_HOLD
    } state_t;

    state_t            state_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [K_W-1:0]    k_reg;
    logic [RAD_W-1:0]  radius_reg;
    fit_status_t       status_reg;
    big_t              acc_reg, ma_reg, mb_reg;
    logic [Q_W-1:0]    q_reg;
    logic [SQ_W-1:0]   res_reg, bit_reg;

    big_t              rf [0:RF_DEPTH-1];
    big_t              rd_a_reg, rd_b_reg;

    uop_t              uop;
    big_t              alu_a, alu_b, alu_sum, load_val, wr_data;
    logic              alu_sub, wr_en, mb_zero;
    alu_flags_t        alu_flags;
    logic [SQ_W-1:0]   sq_trial, rnd;
    logic [Q_W-1:0]    q_next;

    assign uop      = uop_rom(pc_reg);
    assign mb_zero  = (mb_reg == '0);
    assign sq_trial = res_reg + bit_reg;
    assign rnd      = (res_reg + SQ_W'(1)) >> 1;
    assign q_next   = q_reg | (alu_flags.neg ? Q_W'(0) : (Q_W'(1) << k_reg));

    lscr_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .flags (alu_flags)
    );

    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = ma_reg;
        alu_sub = 1'b1;
        unique case (state_reg)
            S_EXEC:
            begin
                alu_a   = rd_a_reg;
                alu_b   = (uop.op == OP_CHK) ? '0 : rd_b_reg;
                alu_sub = (uop.op == OP_SUB);
            end
            S_MUL:   alu_sub = 1'b0;
            S_SQRT:  alu_b   = BIG_W'(sq_trial);
            default: alu_sub = 1'b1;
        endcase
    end

    always_comb
    begin
        unique case (uop.dst)
            R_N:     load_val = BIG_W'(sums.count);
            R_SX:    load_val = BIG_W'(sums.sx);
            R_SY:    load_val = BIG_W'(sums.sy);
            R_SXX:   load_val = BIG_W'(sums.sxx);
            R_SYY:   load_val = BIG_W'(sums.syy);
            R_SX3:   load_val = BIG_W'(sums.sx3);
            R_SY3:   load_val = BIG_W'(sums.sy3);
            R_SXY:   load_val = BIG_W'(sums.sxy);
            R_SXY2:  load_val = BIG_W'(sums.sxy2);
            R_SX2Y:  load_val = BIG_W'(sums.sx2y);
            default: load_val = '0;
        endcase
    end

    always_comb
    begin
        wr_en = ((state_reg == S_EXEC) &&
                 (uop.op == OP_LOAD || uop.op == OP_ADD || uop.op == OP_SUB)) ||
                ((state_reg == S_MUL) && mb_zero);
        if (state_reg == S_MUL)
        begin
            wr_data = acc_reg;
        end
        else if (uop.op == OP_LOAD)
        begin
            wr_data = load_val;
        end
        else
        begin
            wr_data = alu_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf[uop.dst] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= rf[uop.a];
        rd_b_reg <= rf[uop.b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            k_reg      <= '0;
            radius_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    radius_reg <= '0;
                    pc_reg     <= '0;
                    if (sums.overflow)
                    begin
                        status_reg <= ST_OVF;
                        state_reg  <= S_HOLD;
                    end
                    else if (sums.count < CNT_W'(MIN_POINTS))
                    begin
                        status_reg <= ST_FEW;
                        state_reg  <= S_HOLD;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        state_reg  <= S_FETCH;
                    end
                end
                S_FETCH: state_reg <= S_EXEC;
                S_EXEC:
                begin
                    case (uop.op)
                        OP_LOAD, OP_ADD, OP_SUB:
                        begin
                            pc_reg    <= pc_reg + PC_W'(1);
                            state_reg <= S_FETCH;
                        end
                        OP_MUL:
                        begin
                            acc_reg   <= '0;
                            ma_reg    <= rd_a_reg;
                            mb_reg    <= rd_b_reg;
                            state_reg <= S_MUL;
                        end
                        OP_CHK:
                        begin
                            if (alu_flags.zero || alu_flags.neg)
                            begin
                                status_reg <= ST_DEGEN;
                                state_reg  <= S_HOLD;
                            end
                            else
                            begin
                                pc_reg    <= pc_reg + PC_W'(1);
                                state_reg <= S_FETCH;
                            end
                        end
                        OP_DIV:
                        begin
                            if (rd_a_reg[BIG_W-1])
                            begin
                                // negative numerator: quotient is zero
                                acc_reg   <= '0;
                                res_reg   <= '0;
                                bit_reg   <= SQ_BIT0;
                                k_reg     <= K_W'(SQ_ITER - 1);
                                state_reg <= S_SQRT;
                            end
                            else
                            begin
                                acc_reg   <= rd_a_reg;
                                ma_reg    <= rd_b_reg << DIV_SHIFT;
                                state_reg <= S_DSAT;
                            end
                        end
                        default: state_reg <= S_HOLD;
                    endcase
                end
                S_MUL:
                begin
                    if (mb_zero)
                    begin
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        if (mb_reg[0])
                        begin
                            acc_reg <= alu_sum;
                        end
                        ma_reg <= ma_reg << 1;
                        mb_reg <= mb_reg >> 1;
                    end
                end
                S_DSAT:
                begin
                    if (!alu_flags.neg)
                    begin
                        radius_reg <= RADIUS_MAX;
                        state_reg  <= S_HOLD;
                    end
                    else
                    begin
                        ma_reg    <= ma_reg >> 1;
                        k_reg     <= K_W'(Q_W - 1);
                        q_reg     <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!alu_flags.neg)
                    begin
                        acc_reg <= alu_sum;
                    end
                    ma_reg <= ma_reg >> 1;
                    q_reg  <= q_next;
                    k_reg  <= k_reg - K_W'(1);
                    if (k_reg == '0)
                    begin
                        acc_reg   <= BIG_W'(q_next);
                        res_reg   <= '0;
                        bit_reg   <= SQ_BIT0;
                        k_reg     <= K_W'(SQ_ITER - 1);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (!alu_flags.neg)
                    begin
                        acc_reg <= alu_sum;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    k_reg   <= k_reg - K_W'(1);
                    if (k_reg == '0)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    radius_reg <= (rnd > SQ_W'(RADIUS_MAX)) ? RADIUS_MAX : rnd[RAD_W-1:0];
                    state_reg  <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result.valid  = (state_reg == S_HOLD);
    assign result.radius = radius_reg;
    assign result.status = status_reg;

endmodule

// ===== rtl/least_squares_circle_radius.sv =====
// Top level of the least-squares (algebraic) circle radius fit.
`timescale 1ns / 1ps

// Usage:
//   Slave stream: one point per transfer, tdata = {y_depth, x_position}, both
//   signed Q12.4; tlast marks the final point of a set, which starts the fit.
//   Master stream: one transfer per set, tdata = radius (unsigned Q20.4,
//   rounded, saturated), tuser = fit_status (0 ok, 1 fewer than three
//   points, 2 degenerate or collinear, 3 too many points).
// Intake: each point passes through capture, squares, cubes and accumulate;
//   tready drops after each transfer, so a new point is taken only after the last one is accumulated.
// Fit: after the last point the shared 256-bit adder runs a
//   microprogram of 26 shift-add multiplies (which finish early
//   for small positive multipliers), a 51-step divide and a 26-step root;
//   all of it runs on that single adder.
//   tready stays low until the result moves into the output register.
// Reset: all sums, counts and the overflow flag clear at once; no sweep.
// Stall: the result waits in the output register while the receiver holds
//   tready low, and points of the next set are still taken meanwhile; the
//   result of a further fit waits in the solver until the output register frees.
module least_squares_circle_radius (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [2*lscr_pkg::IN_W-1:0]      s_axis_tdata,   // [15:0] x_position, [31:16] y_depth
    input  logic                             s_axis_tlast,   // last_point
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lscr_pkg::RAD_W-1:0]       m_axis_tdata,   // [23:0] radius
    output logic [lscr_pkg::STAT_W-1:0]      m_axis_tuser    // [1:0] fit_status
);
    import lscr_pkg::*;

    logic        s_fire;
    logic        acc_busy, sol_busy, fit_req, take;
    sums_t       sums;
    fit_result_t result;

    logic               out_valid_reg;
    logic [RAD_W-1:0]   out_radius_reg;
    fit_status_t        out_status_reg;

    // Take a point only when both the intake and the solver are free.
    assign s_axis_tready = !acc_busy && !sol_busy;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    lscr_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (s_fire),
        .x_in    (s_axis_tdata[IN_W-1:0]),
        .y_in    (s_axis_tdata[2*IN_W-1:IN_W]),
        .last_in (s_axis_tlast),
        .clr     (take),
        .busy    (acc_busy),
        .fit_req (fit_req),
        .sums    (sums)
    );

    lscr_solver u_solver (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fit_req),
        .sums   (sums),
        .take   (take),
        .busy   (sol_busy),
        .result (result)
    );

    // Move the finished result into the output register when it is free or
    // draining this cycle; this also clears the sums for the next set.
    assign take = result.valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_radius_reg <= result.radius;
            out_status_reg <= result.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_radius_reg;
    assign m_axis_tuser  = out_status_reg;

    // A failed fit always reports a zero radius.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("non-ok status with nonzero radius");

    // A point transfer is followed by intake processing: no back-to-back take.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("point accepted while intake busy");

    // The solver never runs while points are being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        sol_busy |-> !s_axis_tready)
        else $error("ready raised during solve");

endmodule
